[design/cdq_pkg.sv]
package cdq_pkg;

  localparam int DEPTH   = 8;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W  = 32;
  localparam int QDEPTH  = 2;
  localparam int Q_IDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int Q_CNT_W = $clog2(QDEPTH + 1);

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [WORD_W-1:0]  word_t;
  typedef logic [1:0]                kind_t;
  typedef logic [1:0]                status_t;

  localparam kind_t KIND_PUSH_REAR  = 2'd0;
  localparam kind_t KIND_PUSH_FRONT = 2'd1;
  localparam kind_t KIND_DUMP       = 2'd2;
  localparam kind_t KIND_NONE       = 2'd3;

  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_OVERFLOW = 2'd1;
  localparam status_t STAT_EMPTY    = 2'd2;
  localparam status_t STAT_ELEMENT  = 2'd3;

  typedef struct packed {
    kind_t op;
    word_t value;
  } cmd_t;

  function automatic idx_t next_idx(input idx_t i);
    if (i == IDX_W'(DEPTH - 1)) begin
      return '0;
    end
    return i + IDX_W'(1);
  endfunction

  function automatic idx_t prev_idx(input idx_t i);
    if (i == '0) begin
      return IDX_W'(DEPTH - 1);
    end
    return i - IDX_W'(1);
  endfunction

endpackage

[design/cdq_front.sv]
module cdq_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  cdq_pkg::kind_t in_kind,
  input  cdq_pkg::word_t in_push_value,
  output logic           cmd_valid,
  output cdq_pkg::cmd_t  cmd,
  input  logic           cmd_pop
);
  import cdq_pkg::*;

  cmd_t                q_mem [QDEPTH];
  logic [Q_IDX_W-1:0]  head_r, head_nxt;
  logic [Q_IDX_W-1:0]  tail_r, tail_nxt;
  logic [Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                enq;

  function automatic logic [Q_IDX_W-1:0] q_next(input logic [Q_IDX_W-1:0] i);
    if (i == Q_IDX_W'(QDEPTH - 1)) begin
      return '0;
    end
    return i + Q_IDX_W'(1);
  endfunction

  assign busy      = (cnt_r == Q_CNT_W'(QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem[head_r];

  // unused kind is taken but never queued, so it yields nothing
  assign enq = start && !busy && (in_kind != KIND_NONE);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (enq) begin
      tail_nxt = q_next(tail_r);
    end
    if (cmd_pop) begin
      head_nxt = q_next(head_r);
    end
    priority if (enq && !cmd_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (!enq && cmd_pop) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[tail_r] <= '{op: in_kind, value: in_push_value};
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(QDEPTH))
    else $error("command queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cnt_r != '0)
    else $error("command popped from empty queue");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    enq && !cmd_pop |=> cnt_r == $past(cnt_r) + Q_CNT_W'(1))
    else $error("queued command not counted");

endmodule

[design/cdq_back.sv]
module cdq_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  cdq_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             out_valid,
  output cdq_pkg::status_t out_status,
  output cdq_pkg::word_t   out_element,
  output logic             out_is_last
);
  import cdq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  word_t   slot_mem [DEPTH];
  word_t   rd_q_r;

  logic    state_r, state_nxt;
  idx_t    front_r, front_nxt;
  idx_t    rear_r, rear_nxt;
  logic    empty_r, empty_nxt;
  idx_t    pos_r, pos_nxt;

  logic    valid_r, valid_nxt;
  status_t status_r, status_nxt;
  logic    last_r, last_nxt;
  logic    sel_r, sel_nxt;

  logic    we;
  idx_t    waddr;
  logic    full;

  assign full = !empty_r && (next_idx(rear_r) == front_r);

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    empty_nxt  = empty_r;
    pos_nxt    = pos_r;
    valid_nxt  = 1'b0;
    status_nxt = STAT_OK;
    last_nxt   = 1'b1;
    sel_nxt    = 1'b0;
    we         = 1'b0;
    waddr      = '0;
    cmd_pop    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            KIND_PUSH_REAR, KIND_PUSH_FRONT: begin
              valid_nxt = 1'b1;
              priority if (full) begin
                status_nxt = STAT_OVERFLOW;
              end else if (empty_r) begin
                front_nxt = '0;
                rear_nxt  = '0;
                empty_nxt = 1'b0;
                we        = 1'b1;
                waddr     = '0;
              end else if (cmd.op == KIND_PUSH_REAR) begin
                rear_nxt = next_idx(rear_r);
                we       = 1'b1;
                waddr    = next_idx(rear_r);
              end else begin
                front_nxt = prev_idx(front_r);
                we        = 1'b1;
                waddr     = prev_idx(front_r);
              end
            end
            KIND_DUMP: begin
              if (empty_r) begin
                valid_nxt  = 1'b1;
                status_nxt = STAT_EMPTY;
              end else begin
                pos_nxt   = front_r;
                state_nxt = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        // read data for pos_r lands in rd_q_r with the strobe
        valid_nxt  = 1'b1;
        status_nxt = STAT_ELEMENT;
        sel_nxt    = 1'b1;
        last_nxt   = (pos_r == rear_r);
        pos_nxt    = next_idx(pos_r);
        if (pos_r == rear_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      rear_r  <= '0;
      empty_r <= 1'b1;
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      empty_r <= empty_nxt;
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    last_r   <= last_nxt;
    sel_r    <= sel_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem[waddr] <= cmd.value;
    end
    rd_q_r <= slot_mem[pos_r];
  end

  assign out_valid   = valid_r;
  assign out_status  = status_r;
  assign out_is_last = last_r;
  assign out_element = sel_r ? rd_q_r : '0;

  a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP |-> !empty_r)
    else $error("dump running on empty deque");

  a_dump_streams: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |=> out_valid && out_status == STAT_ELEMENT)
    else $error("dump stream broken before last element");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_ELEMENT |-> out_is_last && out_element == '0)
    else $error("push or empty result not a lone last transfer");

endmodule

[design/circular_deque_insert_dump_top.sv]
// Double-ended queue of cdq_pkg::DEPTH signed words. Raise start with in_kind
// and in_push_value while busy is low; busy rises when the two-entry command
// queue is full. Each result appears for exactly one cycle with out_valid
// high and cannot be held off, so the receiver must take every transfer.
// A push (rear or front) gives one result, ok or overflow, in the cycle after
// the back end takes it from the queue; while no dump runs, pushes sustain one
// item per cycle. A dump occupies the back end to start, then to read its n
// elements in turn through the single read port of the slot memory, and
// streams n results back to back, the last flagged by out_is_last; a dump
// of an empty deque gives one empty result. Kind 3 is taken and gives nothing.
module circular_deque_insert_dump_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  cdq_pkg::kind_t   in_kind,
  input  cdq_pkg::word_t   in_push_value,
  output logic             out_valid,
  output cdq_pkg::status_t out_status,
  output cdq_pkg::word_t   out_element,
  output logic             out_is_last
);
  import cdq_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  cdq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_push_value (in_push_value),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  cdq_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_element (out_element),
    .out_is_last (out_is_last)
  );

endmodule
